>>> design/pfd_pkg.sv
// shared types and constants of the padding frame deframer
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int PAD_W   = 8;
   localparam int COUNT_W = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // saturation value of the completed frame counter
   localparam logic [COUNT_W-1:0] FRAMES_TOP = {COUNT_W{1'b1}};

   // decoder phase
   typedef enum logic [2:0] {
      PH_LEN_HI,
      PH_LEN_LO,
      PH_PAD_LEN,
      PH_PAYLOAD,
      PH_PADDING
   } phase_type;

   // register indexes of the csr port
   typedef enum logic [0:0] {
      CSR_LIMIT_ENABLED,
      CSR_FRAME_LIMIT
   } csr_index_type;

   // input transfer
   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              chunk_end;
   } req_type;

   // result transfer
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              passthrough;
   } rsp_type;

   // configuration seen by the front
   typedef struct packed {
      logic              limit_enabled;
      logic [COUNT_W-1:0] frame_limit;
   } cfg_type;

   // queue status seen by the back and by the top-level input handshake
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> design/pfd_front.sv
// front end: header parsing, payload and padding tracking, frame counting, pass-through once the limit is reached
`timescale 1ns / 1ps
`default_nettype none

module pfd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pfd_pkg::cfg_type  cfg,
   input  wire logic              accept,
   input  wire pfd_pkg::req_type  req_data,
   output logic                   push,
   output pfd_pkg::rsp_type       push_data
);
   import pfd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   payload_left_ff, payload_left_in;
   logic [PAD_W-1:0]   padding_left_ff, padding_left_in;
   logic [COUNT_W-1:0] frames_done_ff, frames_done_in;

   logic limit_hit;
   logic payload_last;
   logic padding_last;
   logic pad_byte_zero;
   logic payload_zero;

   // shared conditions
   assign limit_hit     = cfg.limit_enabled && (frames_done_ff >= cfg.frame_limit);
   assign payload_last  = (payload_left_ff == LEN_W'(1));
   assign padding_last  = (padding_left_ff == PAD_W'(1));
   assign pad_byte_zero = (req_data.in_byte == '0);
   assign payload_zero  = (payload_left_ff == '0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_LEN_LO: phase_in = PH_PAD_LEN;
            PH_PAD_LEN: begin
               if (!payload_zero) begin
                  phase_in = PH_PAYLOAD;
               end else if (pad_byte_zero) begin
                  phase_in = PH_LEN_HI;
               end else begin
                  phase_in = PH_PADDING;
               end
            end
            PH_PAYLOAD: begin
               if (payload_last) begin
                  phase_in = (padding_left_ff == '0) ? PH_LEN_HI : PH_PADDING;
               end
            end
            PH_PADDING: begin
               if (padding_last) begin
                  phase_in = PH_LEN_HI;
               end
            end
            default: phase_in = limit_hit ? PH_LEN_HI : PH_LEN_LO;
         endcase
      end
   end

   // counters and result push
   always_comb begin
      payload_left_in       = payload_left_ff;
      padding_left_in       = padding_left_ff;
      frames_done_in        = frames_done_ff;
      push                  = 1'b0;
      push_data.out_byte    = req_data.in_byte;
      push_data.passthrough = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_LEN_LO: begin
               payload_left_in = {payload_left_ff[PAD_W-1:0], req_data.in_byte};
            end
            PH_PAD_LEN: begin
               padding_left_in = req_data.in_byte;
               if (payload_zero && pad_byte_zero && frames_done_ff != FRAMES_TOP) begin
                  frames_done_in = frames_done_ff + COUNT_W'(1);
               end
            end
            PH_PAYLOAD: begin
               push            = 1'b1;
               payload_left_in = payload_left_ff - LEN_W'(1);
               if (payload_last && padding_left_ff == '0 && frames_done_ff != FRAMES_TOP) begin
                  frames_done_in = frames_done_ff + COUNT_W'(1);
               end
            end
            PH_PADDING: begin
               padding_left_in = padding_left_ff - PAD_W'(1);
               if (padding_last && frames_done_ff != FRAMES_TOP) begin
                  frames_done_in = frames_done_ff + COUNT_W'(1);
               end
            end
            default: begin
               if (limit_hit) begin
                  push                  = 1'b1;
                  push_data.passthrough = 1'b1;
               end else begin
                  payload_left_in = LEN_W'(req_data.in_byte);
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEN_HI;
         payload_left_ff <= '0;
         padding_left_ff <= '0;
         frames_done_ff  <= '0;
      end else begin
         phase_ff        <= phase_in;
         payload_left_ff <= payload_left_in;
         padding_left_ff <= padding_left_in;
         frames_done_ff  <= frames_done_in;
      end
   end

   // payload phase is never entered with nothing left to deliver
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> payload_left_ff != '0)
      else $error("payload phase with zero count");

   // padding phase is never entered with nothing left to drop
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PADDING |-> padding_left_ff != '0)
      else $error("padding phase with zero count");

   // pass-through results only come while a frame start is expected
   assert property (@(posedge clock) disable iff (reset)
      push && push_data.passthrough |-> phase_ff != PH_LEN_LO && phase_ff != PH_PAD_LEN
                                        && phase_ff != PH_PAYLOAD && phase_ff != PH_PADDING)
      else $error("pass-through result inside a frame");

endmodule

`default_nettype wire

>>> design/pfd_queue.sv
// small result queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module pfd_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire pfd_pkg::rsp_type          push_data,
   input  wire logic                      pop,
   output pfd_pkg::rsp_type               pop_data,
   output pfd_pkg::queue_status_type      status
);
   import pfd_pkg::*;

   rsp_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   // status flags
   assign status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign pop_data         = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // no write into a full queue unless a read happens in the same cycle
   assert property (@(posedge clock) disable iff (reset) push |-> !status.full || pop)
      else $error("queue overflow");

   // no read from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> status.not_empty)
      else $error("queue underflow");

   // fill count matches pointer distance
   assert property (@(posedge clock) disable iff (reset)
      count_ff == QCNT_W'(QUEUE_DEPTH) || QPTR_W'(wr_ptr_ff - rd_ptr_ff) == QPTR_W'(count_ff))
      else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

>>> design/pfd_back.sv
// back end: result output register fed from the queue
`timescale 1ns / 1ps
`default_nettype none

module pfd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pfd_pkg::queue_status_type     status,
   input  wire pfd_pkg::rsp_type              pop_data,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output pfd_pkg::rsp_type                   rsp_data
);
   import pfd_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // load the output register from the queue whenever it holds an entry and the register is free or being taken
   assign pop = status.not_empty && (!out_valid_ff || rsp_ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         out_data_in  = pop_data;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

>>> design/padding_frame_deframer.sv
// top level of the padding frame deframer
`timescale 1ns / 1ps
`default_nettype none

// Strips padding framing from a byte stream: each frame is a big-endian 16-bit
// payload length, an 8-bit padding length, the payload bytes (delivered with
// passthrough = 0) and the padding bytes (dropped). Once the limit is enabled and
// the completed-frame count has reached frame_limit at a frame start, every byte is
// delivered as is with passthrough = 1. One byte is taken every cycle; a four-entry
// result queue and an output register let the front keep going while the consumer
// stalls, so req_ready drops only when the queue is full. A delivered byte passes
// the result queue and then the output register before it shows on rsp_valid. The
// csr port is always ready and writes registers 0 limit_enabled and 1 frame_limit;
// the user must write them only while idle; the block itself does not enforce it.
module padding_frame_deframer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire pfd_pkg::req_type        req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output pfd_pkg::rsp_type             rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire pfd_pkg::csr_index_type  csr_index,
   input  wire logic [15:0]             csr_wdata
);
   import pfd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type status;
   logic             accept;
   logic             push;
   rsp_type          push_data;
   logic             pop;
   rsp_type          pop_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LIMIT_ENABLED: cfg_in.limit_enabled = csr_wdata[0];
            CSR_FRAME_LIMIT:   cfg_in.frame_limit   = csr_wdata[COUNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input transfer
   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;

   pfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data)
   );

   pfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   pfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench for the padding frame deframer with its own byte predictor
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import pfd_pkg::*;

   // run limits and timing
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_ITEMS  = 450;
   localparam int PHASE_ITEMS   = 150;
   localparam int IDLE_PERCENT  = 34;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_LIMIT_ENABLED;
   logic [15:0]   csr_wdata = '0;

   // shared test state
   int  failures = 0;
   int  cycle_count = 0;
   int  accepted_items = 0;
   int  rsp_hold_cycles = 0;
   bit  idle_on = 1'b1;
   rsp_type pending_bytes[$];
   rsp_type got_byte;
   rsp_type want_byte;

   // mirror of the deframer state and registers
   phase_type         dec_phase = PH_LEN_HI;
   logic [LEN_W-1:0]  dec_payload_left = '0;
   logic [PAD_W-1:0]  dec_padding_left = '0;
   logic [COUNT_W-1:0] dec_frames_done = '0;
   logic              cfg_limit_enabled = 1'b0;
   logic [COUNT_W-1:0] cfg_frame_limit = '0;

   padding_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // frame completion, counter saturates at the top
   task automatic end_frame;
      if (dec_frames_done != FRAMES_TOP)
         dec_frames_done++;
      dec_phase = PH_LEN_HI;
   endtask

   // payload done: padding or straight to frame end
   task automatic close_payload;
      if (dec_padding_left == 0)
         end_frame();
      else
         dec_phase = PH_PADDING;
   endtask

   // advance the mirror by one byte and queue the delivered byte, if any
   task automatic deframe_byte(input logic [7:0] value);
      case (dec_phase)
         PH_LEN_LO: begin
            dec_payload_left = {dec_payload_left[7:0], value};
            dec_phase = PH_PAD_LEN;
         end
         PH_PAD_LEN: begin
            dec_padding_left = value;
            if (dec_payload_left == 0)
               close_payload();
            else
               dec_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            pending_bytes.push_back('{out_byte: value, passthrough: 1'b0});
            dec_payload_left--;
            if (dec_payload_left == 0)
               close_payload();
         end
         PH_PADDING: begin
            dec_padding_left--;
            if (dec_padding_left == 0)
               end_frame();
         end
         default: begin
            dec_phase = PH_LEN_HI;
            if (cfg_limit_enabled && dec_frames_done >= cfg_frame_limit) begin
               pending_bytes.push_back('{out_byte: value, passthrough: 1'b1});
            end else begin
               dec_payload_left = {8'h00, value};
               dec_phase = PH_LEN_LO;
            end
         end
      endcase
   endtask

   // consumer side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_byte = rsp_data;
         if (pending_bytes.size() == 0) begin
            $error("result with no expectation waiting: out_byte %02h passthrough %0b",
                   got_byte.out_byte, got_byte.passthrough);
            failures++;
         end else begin
            want_byte = pending_bytes.pop_front();
            if (got_byte.out_byte !== want_byte.out_byte) begin
               $error("out_byte: expected %02h, actual %02h",
                      want_byte.out_byte, got_byte.out_byte);
               failures++;
            end
            if (got_byte.passthrough !== want_byte.passthrough) begin
               $error("passthrough: expected %0b, actual %0b",
                      want_byte.passthrough, got_byte.passthrough);
               failures++;
            end
         end
      end
   end

   // one byte transfer on the input channel
   task automatic send_byte(input logic [7:0] value);
      req_type item;
      item.in_byte   = value;
      item.chunk_end = 1'($urandom_range(1));
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      deframe_byte(item.in_byte);
      accepted_items++;
   endtask

   // header, random payload, random padding
   task automatic send_frame(input logic [15:0] len, input logic [7:0] pad);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      send_byte(pad);
      repeat (len) send_byte(8'($urandom_range(255)));
      repeat (pad) send_byte(8'($urandom_range(255)));
   endtask

   // sender pause until every expected byte came out
   task automatic wait_for_results;
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // register write while the block is idle
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LIMIT_ENABLED: cfg_limit_enabled = value[0];
         CSR_FRAME_LIMIT:   cfg_frame_limit   = value;
         default: ;
      endcase
   endtask

   // limit of zero from reset, limit reached after frames, change in mid frame
   task automatic test_frame_limit;
      write_reg(CSR_LIMIT_ENABLED, 16'd1);
      send_byte(8'h00);
      send_byte(8'hFF);
      write_reg(CSR_FRAME_LIMIT, 16'd2);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_frame(16'd1, 8'd0);
      send_byte(8'h80);
      // raise the limit, then lower it while inside the payload
      write_reg(CSR_FRAME_LIMIT, 16'hFFFF);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'h3C);
      write_reg(CSR_FRAME_LIMIT, 16'd3);
      send_byte(8'hC3);
      send_byte(8'h7E);
      write_reg(CSR_LIMIT_ENABLED, 16'd0);
   endtask

   // plain frames with zero-length phases and byte extremes
   task automatic test_basic_frames;
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(16'd0, 8'd0);
      send_frame(16'd0, 8'd2);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      wait_for_results();
   endtask

   // consumer holds off while the sender keeps offering payload
   task automatic test_backpressure;
      idle_on = 1'b0;
      @(posedge clock);
      rsp_hold_cycles = 120;
      send_frame(16'd40, 8'd2);
      wait_for_results();
      idle_on = 1'b1;
   endtask

   // nonzero high length byte and the largest padding, with no idling
   task automatic test_long_frames;
      idle_on = 1'b0;
      send_frame(16'h0100, 8'hFF);
      wait_for_results();
      idle_on = 1'b1;
   endtask

   // random frames in phases of random register settings
   task automatic test_random_traffic;
      int start_count;
      int phase_start;
      int pick;
      int limit_value;
      logic [15:0] len;
      logic [7:0]  pad;
      start_count = accepted_items;
      while (accepted_items - start_count < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(3) != 0);
         pick = $urandom_range(3);
         case (pick)
            0: limit_value = $urandom_range(16'hFFFF);
            1: limit_value = dec_frames_done + $urandom_range(1, 4);
            2: limit_value = 16'hFFFF;
            default: limit_value = $urandom_range(dec_frames_done);
         endcase
         if (limit_value > 16'hFFFF)
            limit_value = 16'hFFFF;
         write_reg(CSR_LIMIT_ENABLED, (pick == 0) ? 16'd0 : 16'd1);
         write_reg(CSR_FRAME_LIMIT, limit_value[15:0]);
         phase_start = accepted_items;
         while (accepted_items - phase_start < PHASE_ITEMS) begin
            if (dec_phase == PH_LEN_HI && cfg_limit_enabled
                && dec_frames_done >= cfg_frame_limit) begin
               // unframed bytes once the limit is reached
               send_byte(8'($urandom_range(255)));
            end else begin
               pick = $urandom_range(99);
               if (pick < 15)      len = '0;
               else if (pick < 85) len = 16'($urandom_range(1, 8));
               else                len = 16'($urandom_range(9, 40));
               pick = $urandom_range(99);
               if (pick < 45)      pad = '0;
               else if (pick < 95) pad = 8'($urandom_range(1, 5));
               else                pad = 8'($urandom_range(6, 255));
               send_frame(len, pad);
            end
         end
      end
      wait_for_results();
      idle_on = 1'b1;
   endtask

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frame_limit();
      test_basic_frames();
      test_backpressure();
      test_long_frames();
      test_random_traffic();
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         $error("%0d expected bytes never delivered", pending_bytes.size());
         failures++;
      end
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
